FILE: src/pc2g6_pkg.sv
// ============================================================================
// pc2g6_pkg: shared types and constants of the planar code to graph6 encoder
// Sizes, graph6 character codes, the front-to-back request word and the
// back-end state type.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pc2g6_pkg;

	// Largest vertex count; larger counts saturate to this
	localparam int MAX_VERTICES = 64;

	// Vertex count 0..MAX_VERTICES
	localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
	// Column length 0..MAX_VERTICES-1
	localparam int LEN_W = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;

	// Body bits are 6 per character
	localparam int GROUP_W = 6;
	localparam int CNT_W   = 3;

	// Column shift register, held bit-reversed so the first bit sits at the top
	localparam int ROW_W     = (MAX_VERTICES < GROUP_W) ? GROUP_W : MAX_VERTICES;
	localparam int ROW_IDX_W = $clog2(ROW_W);

	// graph6 character codes
	localparam logic [7:0] G6_BIAS      = 8'd63;
	localparam logic [7:0] G6_LONG      = 8'd126;
	localparam logic [7:0] G6_NEWLINE   = 8'd10;
	localparam logic [7:0] G6_SMALL_MAX = 8'd62;
	localparam logic [7:0] G6_LOW_MASK  = 8'h3F;

	// Request queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef enum logic {
		REQ_HDR,
		REQ_COL
	} req_kind_t;

	typedef struct packed {
		req_kind_t          kind;
		logic               last;
		logic [VCNT_W-1:0]  count;
		logic [LEN_W-1:0]   len;
		logic [ROW_W-1:0]   bits;
	} req_t;

	// Queue to back end handshake
	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_HDR,
		BK_COL,
		BK_NL
	} back_state_t;

endpackage

`default_nettype wire

FILE: src/pc2g6_front.sv
// ============================================================================
// pc2g6_front: input stage of the graph6 encoder
// Accepts code items, tracks the graph and current vertex, collects the
// column bits and queues header and column requests.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pc2g6_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 is_count,
	input  wire logic [7:0]           code_value,
	input  wire pc2g6_pkg::q_status_t q_stat,
	output logic                      push,
	output pc2g6_pkg::req_t           req
);

	logic [pc2g6_pkg::VCNT_W-1:0]    total_q;
	logic [pc2g6_pkg::VCNT_W-1:0]    cur_q;
	logic [pc2g6_pkg::ROW_W-1:0]     row_q;
	logic                            accept;
	logic                            active;
	logic                            list_end;
	logic                            nb_ok;
	logic [pc2g6_pkg::VCNT_W-1:0]    n_sat;
	logic [pc2g6_pkg::VCNT_W:0]      cur_next;
	logic [8:0]                      rev_idx;
	logic                            last_col;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign active   = cur_q < total_q;
	assign list_end = !is_count && active && (code_value == 8'd0);
	assign nb_ok    = !is_count && active && (code_value != 8'd0)
		&& (code_value <= 8'(cur_q));
	assign n_sat    = (code_value > 8'(pc2g6_pkg::MAX_VERTICES))
		? pc2g6_pkg::VCNT_W'(pc2g6_pkg::MAX_VERTICES)
		: pc2g6_pkg::VCNT_W'(code_value);
	// neighbour j lands at ROW_W - j so the column reads out from the top
	assign rev_idx  = 9'(pc2g6_pkg::ROW_W) - {1'b0, code_value};
	assign cur_next = {1'b0, cur_q} + 1'b1;
	assign last_col = cur_next >= {1'b0, total_q};

	always_comb begin
		push       = accept && (is_count || list_end);
		req.kind   = is_count ? pc2g6_pkg::REQ_HDR : pc2g6_pkg::REQ_COL;
		req.last   = last_col;
		req.count  = n_sat;
		req.len    = pc2g6_pkg::LEN_W'(cur_q);
		req.bits   = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			cur_q   <= '0;
			row_q   <= '0;
		end else if (accept) begin
			if (is_count) begin
				total_q <= n_sat;
				cur_q   <= '0;
				row_q   <= '0;
			end else if (list_end) begin
				row_q <= '0;
				cur_q <= last_col ? total_q : cur_next[pc2g6_pkg::VCNT_W-1:0];
			end else if (nb_ok) begin
				row_q[rev_idx[pc2g6_pkg::ROW_IDX_W-1:0]] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/pc2g6_queue.sv
// ============================================================================
// pc2g6_queue: request queue between front and back
// Small FIFO of requests, push and pop in the same cycle allowed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pc2g6_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pc2g6_pkg::req_t  push_req,
	input  wire logic             pop,
	output pc2g6_pkg::req_t       head,
	output pc2g6_pkg::q_status_t  stat
);

	pc2g6_pkg::req_t              entry_q [pc2g6_pkg::Q_DEPTH];
	logic [pc2g6_pkg::QPTR_W-1:0] wr_q;
	logic [pc2g6_pkg::QPTR_W-1:0] rd_q;
	logic [pc2g6_pkg::QCNT_W-1:0] cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign stat.valid = cnt_q != '0;
	assign stat.full  = cnt_q == pc2g6_pkg::QCNT_W'(pc2g6_pkg::Q_DEPTH);
	assign head       = entry_q[rd_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;

	function automatic logic [pc2g6_pkg::QPTR_W-1:0] next_ptr(
		input logic [pc2g6_pkg::QPTR_W-1:0] p
	);
		next_ptr = (p == pc2g6_pkg::QPTR_W'(pc2g6_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (do_pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/pc2g6_back.sv
// ============================================================================
// pc2g6_back: output stage of the graph6 encoder
// Turns queued requests into header bytes, 6-bit body characters and the
// closing newline, one character per cycle while not stalled, into an output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pc2g6_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pc2g6_pkg::req_t      head,
	input  wire pc2g6_pkg::q_status_t q_stat,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                out_char,
	output logic                      end_of_graph
);

	pc2g6_pkg::back_state_t          state_q, state_d;
	logic [pc2g6_pkg::ROW_W-1:0]     sr_q, sr_d;
	logic [pc2g6_pkg::LEN_W-1:0]     rem_q, rem_d;
	logic                            last_q, last_d;
	logic [pc2g6_pkg::GROUP_W-1:0]   carry_q, carry_d;
	logic [pc2g6_pkg::CNT_W-1:0]     cc_q, cc_d;
	logic [pc2g6_pkg::VCNT_W-1:0]    n_q, n_d;
	logic [1:0]                      idx_q, idx_d;

	logic                            out_valid_q;
	logic [7:0]                      out_char_q;
	logic                            end_q;

	logic                            emit_ok;
	logic                            emit;
	logic [7:0]                      emit_char;
	logic                            emit_end;

	logic [pc2g6_pkg::GROUP_W-1:0]   top6;
	logic [pc2g6_pkg::CNT_W-1:0]     need;
	logic [pc2g6_pkg::CNT_W-1:0]     rem3;
	logic [8:0]                      total;
	logic [11:0]                     hi_w;
	logic [11:0]                     abs_w;
	logic [pc2g6_pkg::GROUP_W-1:0]   grp;
	logic [7:0]                      n8;

	assign emit_ok = !out_valid_q || !out_stall;
	assign top6    = sr_q[pc2g6_pkg::ROW_W-1 -: pc2g6_pkg::GROUP_W];
	assign need    = pc2g6_pkg::CNT_W'(pc2g6_pkg::GROUP_W) - cc_q;
	assign rem3    = pc2g6_pkg::CNT_W'(rem_q);
	assign total   = 9'(rem_q) + 9'(cc_q);
	// carried bits on top, fresh column bits below them
	assign hi_w    = {6'd0, carry_q} << need;
	assign grp     = hi_w[5:0] | (top6 >> cc_q);
	assign abs_w   = {6'd0, carry_q} << rem3;
	assign n8      = 8'(n_q);

	always_comb begin
		state_d   = state_q;
		sr_d      = sr_q;
		rem_d     = rem_q;
		last_d    = last_q;
		carry_d   = carry_q;
		cc_d      = cc_q;
		n_d       = n_q;
		idx_d     = idx_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_char = pc2g6_pkg::G6_NEWLINE;
		emit_end  = 1'b0;
		case (state_q)
			pc2g6_pkg::BK_IDLE: begin
				if (q_stat.valid) begin
					pop = 1'b1;
					if (head.kind == pc2g6_pkg::REQ_HDR) begin
						n_d     = head.count;
						idx_d   = 2'd0;
						carry_d = '0;
						cc_d    = '0;
						state_d = pc2g6_pkg::BK_HDR;
					end else begin
						sr_d    = head.bits;
						rem_d   = head.len;
						last_d  = head.last;
						state_d = pc2g6_pkg::BK_COL;
					end
				end
			end
			pc2g6_pkg::BK_HDR: begin
				if (emit_ok) begin
					emit = 1'b1;
					if (n8 <= pc2g6_pkg::G6_SMALL_MAX) begin
						emit_char = pc2g6_pkg::G6_BIAS + n8;
						state_d   = (n_q == '0) ? pc2g6_pkg::BK_NL : pc2g6_pkg::BK_IDLE;
					end else begin
						case (idx_q)
							2'd0:    emit_char = pc2g6_pkg::G6_LONG;
							2'd1:    emit_char = pc2g6_pkg::G6_BIAS;
							2'd2:    emit_char = pc2g6_pkg::G6_BIAS + (n8 >> 6);
							default: emit_char = pc2g6_pkg::G6_BIAS
								+ (n8 & pc2g6_pkg::G6_LOW_MASK);
						endcase
						idx_d = idx_q + 1'b1;
						if (idx_q == 2'd3) begin
							state_d = pc2g6_pkg::BK_IDLE;
						end
					end
				end
			end
			pc2g6_pkg::BK_COL: begin
				if (total >= 9'(pc2g6_pkg::GROUP_W)) begin
					if (emit_ok) begin
						emit      = 1'b1;
						emit_char = pc2g6_pkg::G6_BIAS + 8'(grp);
						sr_d      = sr_q << need;
						rem_d     = rem_q - pc2g6_pkg::LEN_W'(need);
						carry_d   = '0;
						cc_d      = '0;
					end
				end else if (last_q) begin
					// zero-padded remainder, then the newline
					if (total != '0) begin
						if (emit_ok) begin
							emit      = 1'b1;
							emit_char = pc2g6_pkg::G6_BIAS + 8'(grp);
							rem_d     = '0;
							carry_d   = '0;
							cc_d      = '0;
							state_d   = pc2g6_pkg::BK_NL;
						end
					end else begin
						state_d = pc2g6_pkg::BK_NL;
					end
				end else begin
					// short tail joins the carry
					carry_d = abs_w[5:0]
						| (top6 >> (pc2g6_pkg::CNT_W'(pc2g6_pkg::GROUP_W) - rem3));
					cc_d    = cc_q + rem3;
					rem_d   = '0;
					state_d = pc2g6_pkg::BK_IDLE;
				end
			end
			pc2g6_pkg::BK_NL: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_char = pc2g6_pkg::G6_NEWLINE;
					emit_end  = 1'b1;
					carry_d   = '0;
					cc_d      = '0;
					state_d   = pc2g6_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = pc2g6_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pc2g6_pkg::BK_IDLE;
			cc_q    <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cc_q    <= cc_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		sr_q    <= sr_d;
		rem_q   <= rem_d;
		last_q  <= last_d;
		carry_q <= carry_d;
		n_q     <= n_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			end_q      <= emit_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign end_of_graph = end_q;

endmodule

`default_nettype wire

FILE: src/planar_code_to_graph6_top.sv
// ============================================================================
// planar_code_to_graph6_top: planar code to graph6 text encoder
// Front stage, request queue and character back stage.
// ============================================================================
// Usage
//   Input channel (in_valid / in_stall, fields is_count and code_value): an
//   item with is_count set opens a graph of code_value vertices (saturated to
//   the maximum); later items are neighbour numbers, 0 closing a vertex list.
//   Output channel (out_valid / out_stall, fields out_char and end_of_graph):
//   one graph6 character per request; end_of_graph marks the final newline.
// Timing
//   Neighbour items are taken one per cycle while in_stall is low and give no
//   output. A count or a list end becomes a request in a two-entry queue;
//   the back stage pops it from the queue head when idle and registers its
//   characters in the output register.
//   The back stage takes a request in its idle state, then emits its
//   characters one by one (header up to 4, body up to 11 plus newline); a
//   column request ends its column state without output, except on a last
//   list that closes with a padded character. in_stall rises only while the
//   queue is full, so the output rate sets the throughput.
// Reset and back-pressure
//   arst_n clears the graph, the queue and the output valid flag: no graph is
//   active and out_valid is low. While out_stall is high the shown character
//   holds; the back stage waits, then the queue fills and in_stall rises.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module planar_code_to_graph6_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       is_count,
	input  wire logic [7:0] code_value,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            end_of_graph
);

	// requests from front to queue
	pc2g6_pkg::req_t      push_req;
	logic                 push;
	// queue head and status towards back
	pc2g6_pkg::req_t      head;
	pc2g6_pkg::q_status_t q_stat;
	logic                 pop;

	// Front: tracks vertex count and current vertex, gathers the column
	pc2g6_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.is_count   (is_count),
		.code_value (code_value),
		.q_stat     (q_stat),
		.push       (push),
		.req        (push_req)
	);

	// Queue: decouples input acceptance from character output
	pc2g6_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// Back: holds the 6-bit carry across columns and emits characters
	pc2g6_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.end_of_graph (end_of_graph)
	);

endmodule

`default_nettype wire

FILE: src/pc2g6_checker.sv
// ============================================================================
// pc2g6_checker: port checks of the graph6 encoder
// Watches the output channel for held requests and legal characters.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pc2g6_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       is_count,
	input wire logic [7:0] code_value,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_char,
	input wire logic       end_of_graph
);

	// a stalled output request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(end_of_graph))
		else $error("output request changed while stalled");

	// the end marker only ever rides on the newline
	a_end_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_graph |-> out_char == 8'd10)
		else $error("end_of_graph on a character other than newline");

	// header and body characters all lie in the printable graph6 range
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_graph |-> out_char >= 8'd63 && out_char <= 8'd126)
		else $error("graph6 character out of range");

endmodule

bind planar_code_to_graph6_top pc2g6_checker u_pc2g6_checker (.*);

`default_nettype wire

FILE: tb/tb_planar_code_to_graph6_top.sv
// ============================================================================
// tb_planar_code_to_graph6_top: self-checking bench for the graph6 encoder
// Drives vertex counts and neighbour lists into the encoder. Each accepted
// request is run through a cycle-free model of the encoder, which queues the
// graph6 characters it should give. Each character taken from the output is
// checked against the oldest one queued. Directed cases come first, then
// random graphs, with bursts of back-pressure on both sides.
// ============================================================================
`timescale 1ns / 1ps

// One graph6 character as the output channel shows it
typedef struct packed {
	logic [7:0] ch;
	logic       eog;
} g6_char_t;

// Scoreboard: a model of the encoder plus the queue of characters it predicts
class g6_scoreboard;
	int unsigned mismatches;
	g6_char_t    pending_chars[$];

	// Model state: graph size, vertex whose list is arriving, its column,
	// and the body bits still short of a full character
	int unsigned                        vtotal;
	int unsigned                        vcur;
	logic [pc2g6_pkg::MAX_VERTICES-1:0] column;
	logic [5:0]                         carry;
	int unsigned                        carry_n;

	function new();
		mismatches = 0;
		vtotal     = 0;
		vcur       = 0;
		column     = '0;
		carry      = '0;
		carry_n    = 0;
	endfunction

	function void push_char(logic [7:0] c, logic e);
		pending_chars.push_back('{ch: c, eog: e});
	endfunction

	function int unsigned outstanding();
		return pending_chars.size();
	endfunction

	// Work out the characters caused by one accepted request
	function void note_request(logic c, logic [7:0] v);
		int unsigned n;
		logic [5:0]  padded;
		if (c) begin
			n       = (v > pc2g6_pkg::MAX_VERTICES) ? pc2g6_pkg::MAX_VERTICES : v;
			vtotal  = n;
			vcur    = 0;
			column  = '0;
			carry   = '0;
			carry_n = 0;
			if (n <= 62) begin
				push_char(8'(63 + n), 1'b0);
			end else begin
				push_char(8'd126, 1'b0);
				push_char(8'd63, 1'b0);
				push_char(8'(63 + (n >> 6)), 1'b0);
				push_char(8'(63 + (n & 63)), 1'b0);
			end
			if (n == 0)
				push_char(8'd10, 1'b1);
			return;
		end
		// no graph open: ignored
		if (vcur >= vtotal)
			return;
		if (v != 0) begin
			// lower neighbours only; loops and higher ones drop out
			if (v <= vcur)
				column[v - 1] = 1'b1;
			return;
		end
		// list end: column bits go out MSB-first in groups of six
		for (int b = 0; b < vcur; b++) begin
			carry = {carry[4:0], column[b]};
			carry_n++;
			if (carry_n == 6) begin
				push_char(8'(carry + 63), 1'b0);
				carry   = '0;
				carry_n = 0;
			end
		end
		column = '0;
		if (vcur + 1 >= vtotal) begin
			if (carry_n != 0) begin
				padded = carry << (6 - carry_n);
				push_char(8'(padded + 63), 1'b0);
			end
			carry   = '0;
			carry_n = 0;
			push_char(8'd10, 1'b1);
			vcur = vtotal;
		end else begin
			vcur++;
		end
	endfunction

	task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		mismatches++;
		$display("%0t ns: %s wrong, got %0d, expected %0d", $time, what, got, want);
	endtask

	task check_char(logic [7:0] c, logic e);
		g6_char_t want;
		if (pending_chars.size() == 0) begin
			report_mismatch("unexpected character", c, 8'd0);
		end else begin
			want = pending_chars.pop_front();
			if (c !== want.ch)
				report_mismatch("out_char", c, want.ch);
			if (e !== want.eog)
				report_mismatch("end_of_graph", {7'd0, e}, {7'd0, want.eog});
		end
	endtask
endclass

module tb_planar_code_to_graph6_top;

	// Worst case is far below this: ~160 requests, each at most 12 characters
	// that each wait out the longest stall burst, plus one long hold
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Slack after draining before the final check; leave room
	localparam int unsigned DRAIN_TAIL  = 24;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       is_count;
	logic [7:0] code_value;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       end_of_graph;

	g6_scoreboard sb;

	// Idling control: calm turns bursts off for a stretch, quiet for the
	// tail of the run; long_hold_req asks the receiver for a long hold-off
	bit          calm;
	bit          quiet;
	bit          long_hold_req;
	int unsigned items_sent;
	int unsigned cycles;

	planar_code_to_graph6_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.is_count     (is_count),
		.code_value   (code_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.end_of_graph (end_of_graph)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one request and hold it until taken. in_stall read just after
	// the edge is the value that edge saw, so the loop ends on acceptance.
	task automatic send_item(logic c, logic [7:0] v);
		in_valid   <= 1'b1;
		is_count   <= c;
		code_value <= v;
		do @(posedge clk); while (in_stall);
		sb.note_request(c, v);
		items_sent++;
		// random gap after the request; in_valid drops only when one is taken
		if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted character has come out.
	// The first edge keeps the drop of in_valid apart from any later raise.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// One graph: the count, then a list per vertex. Neighbours are mostly
	// lower (giving edges, with duplicates), sometimes the vertex itself or
	// anything up to 255. A cut inside the graph leaves it unfinished, so the
	// next count drops it.
	task automatic send_graph(logic [7:0] count, int cut, int nb_max);
		int n;
		int k;
		n = (count > pc2g6_pkg::MAX_VERTICES) ? pc2g6_pkg::MAX_VERTICES : count;
		send_item(1'b1, count);
		for (int i = 0; i < n; i++) begin
			if (i == cut)
				return;
			k = $urandom_range(0, nb_max);
			repeat (k) begin
				if ($urandom_range(0, 3) != 0)
					send_item(1'b0, 8'($urandom_range(1, i + 1)));
				else
					send_item(1'b0, 8'($urandom_range(1, 255)));
			end
			send_item(1'b0, 8'd0);
		end
	endtask

	// Receiver: checks each character taken and sets out_stall for the next
	// edge. Random bursts of stall, plus one long hold on request.
	initial begin
		int unsigned hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_char(out_char, end_of_graph);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold          = 400;
			end
			if (hold != 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		is_count      <= 1'b0;
		code_value    <= 8'd0;
		calm          = 1'b0;
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		items_sent    = 0;
		sb            = new();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// neighbour and list end with no graph open: no output
		send_item(1'b0, 8'd5);
		send_item(1'b0, 8'd0);
		// empty graph: header and newline at once
		send_item(1'b1, 8'd0);
		// single vertex: header, then newline on its list end
		send_item(1'b1, 8'd1);
		send_item(1'b0, 8'd0);
		// three vertices: loop on v0, duplicate edge on v1, loop and higher
		// neighbours on v2, padded remainder on the last list
		send_item(1'b1, 8'd3);
		send_item(1'b0, 8'd1);
		send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd1);
		send_item(1'b0, 8'd1);
		send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd2);
		send_item(1'b0, 8'd3);
		send_item(1'b0, 8'd255);
		send_item(1'b0, 8'd1);
		send_item(1'b0, 8'd0);
		// graph finished: ignored
		send_item(1'b0, 8'd7);
		// largest short header, then the long form; each count drops the
		// unfinished graph before it; 255 and 128 saturate
		send_item(1'b1, 8'd62);
		send_item(1'b1, 8'd63);
		send_item(1'b1, 8'd255);
		send_item(1'b1, 8'd128);
		send_item(1'b1, 8'd2);
		send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd1);
		send_item(1'b0, 8'd0);

		// --- random part ---
		// long receiver hold while requests keep coming: queue fills
		long_hold_req = 1'b1;
		// one full-size graph, sparse, so columns run up to the top bit
		send_graph(8'($urandom_range(64, 255)), -1, 1);
		// sender pause until the output is fully drained
		wait_drained();

		while (items_sent < 140) begin
			if ($urandom_range(0, 3) == 0)
				calm = !calm;
			if (items_sent >= 128)
				quiet = 1'b1;
			case ($urandom_range(0, 9))
				0: send_item(1'b0, 8'($urandom));
				1: send_graph(8'($urandom_range(2, 9)), $urandom_range(0, 4), 3);
				2: send_graph(8'($urandom_range(10, 30)), -1, 2);
				default: send_graph(8'($urandom_range(0, 9)), -1, 4);
			endcase
		end

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
src/pc2g6_pkg.sv
src/pc2g6_front.sv
src/pc2g6_queue.sv
src/pc2g6_back.sv
src/planar_code_to_graph6_top.sv
src/pc2g6_checker.sv
tb/tb_planar_code_to_graph6_top.sv
